>>> rtl/bghp_pkg.sv
package bghp_pkg;

  // Table geometry: every counter table is indexed by up to this many address bits
  localparam int INDEX_BITS = 14;
  localparam int TABLE_DEPTH = 1 << INDEX_BITS;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_INDEX_W-1:0] CFG_MODE         = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BIMODAL_BITS = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_GSHARE_BITS  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_HISTORY_BITS = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHOOSER_BITS = 3'd4;

  // Predictor modes; any other code runs the hybrid
  localparam logic [1:0] MODE_BIMODAL = 2'd0;
  localparam logic [1:0] MODE_GSHARE  = 2'd1;

  // Counter values
  localparam logic [1:0] CTR_MIN          = 2'd0;
  localparam logic [1:0] CTR_MAX          = 2'd3;
  localparam logic [1:0] CTR_WEAK_TAKEN   = 2'd2;
  localparam logic [1:0] CHOOSER_RESET    = 2'd1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clear;   // write reset values at the sweep address
    logic load;    // capture an incoming branch
    logic read;    // read all three tables
    logic commit;  // train, update history and totals, load the result
  } bghp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clear_last;  // sweep address is at the last entry
  } bghp_status_t;

  // Limit an index length to 1..hi
  function automatic logic [3:0] clamp_bits(input logic [3:0] v, input logic [3:0] hi);
    if (v == 4'd0) begin
      return 4'd1;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  // Mask of the low 'bits' bits, bits in 1..INDEX_BITS
  function automatic logic [INDEX_BITS-1:0] low_mask(input logic [3:0] bits);
    logic [INDEX_BITS:0] one_hot;
    logic [INDEX_BITS:0] diff;
    one_hot = {{INDEX_BITS{1'b0}}, 1'b1} << bits;
    diff = one_hot - {{INDEX_BITS{1'b0}}, 1'b1};
    return diff[INDEX_BITS-1:0];
  endfunction

  // Two-bit saturating counter step
  function automatic logic [1:0] train(input logic [1:0] c, input logic t);
    if (t) begin
      return (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
    end
    return (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
  endfunction

endpackage

>>> rtl/bimodal_gshare_hybrid_branch_predictor_core.sv
// Tournament branch predictor (bimodal, gshare or a hybrid chooser of both) that
// trains on resolved branches. After reset the block sweeps its three 16384-entry
// counter tables to their initial values, one entry per cycle, and takes no branch
// until the sweep ends; configuration writes are accepted at any time, and cfg_ready
// is always high. Each branch then goes through capture, a registered read of the
// bimodal, gshare and chooser tables, and a write-back that trains the counters,
// shifts the global history (not in bimodal mode) and loads the result register.
// The single read-modify-write pass through the tables lets a new branch in only
// after the last is written back. A done result waits in its register while the
// next branch is captured and read; its write-back holds until the result is taken.
module bimodal_gshare_hybrid_branch_predictor_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic [31:0]                      branch_address,
  input  logic                             taken,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic                             predicted_taken,
  output logic                             mispredicted,
  output logic [31:0]                      prediction_total,
  output logic [31:0]                      mispredict_total,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bghp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bghp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bghp_pkg::*;

  bghp_cmd_t    cmd;
  bghp_status_t status;

  assign cfg_ready = 1'b1;

  bghp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  bghp_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .cfg_write        (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .branch_address   (branch_address),
    .taken            (taken),
    .predicted_taken  (predicted_taken),
    .mispredicted     (mispredicted),
    .prediction_total (prediction_total),
    .mispredict_total (mispredict_total)
  );

  // Never overwrite a result that is still waiting
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!result_valid || !result_stall))
    else $error("result overwritten while stalled");

  // A committed branch shows up as a result
  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> result_valid)
    else $error("commit without result");

  // Commands are mutually exclusive
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear, cmd.load, cmd.read, cmd.commit}))
    else $error("overlapping datapath commands");

  // No branch is taken during the table sweep
  a_no_item_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> item_stall)
    else $error("branch accepted during table clear");

endmodule

>>> rtl/bghp_ctrl.sv
module bghp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  output logic                  result_valid,
  input  logic                  result_stall,
  input  bghp_pkg::bghp_status_t status,
  output bghp_pkg::bghp_cmd_t    cmd
);
  import bghp_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE
  } state_t;

  state_t state;

  // Decode commands from the current state
  always_comb begin
    cmd.clear  = (state == ST_CLEAR);
    cmd.load   = (state == ST_IDLE) && item_valid;
    cmd.read   = (state == ST_READ);
    cmd.commit = (state == ST_WRITE) && (!result_valid || !result_stall);
  end

  // Take a branch only when idle
  assign item_stall = (state != ST_IDLE);

  // Hold state and the result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      result_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (status.clear_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (item_valid) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          if (cmd.commit) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase

      if (cmd.commit) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/bghp_dp.sv
module bghp_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  bghp_pkg::bghp_cmd_t                 cmd,
  output bghp_pkg::bghp_status_t              status,
  input  logic                                cfg_write,
  input  logic [bghp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bghp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [31:0]                         branch_address,
  input  logic                                taken,
  output logic                                predicted_taken,
  output logic                                mispredicted,
  output logic [31:0]                         prediction_total,
  output logic [31:0]                         mispredict_total
);
  import bghp_pkg::*;

  // Configuration registers
  logic [1:0] mode;
  logic [3:0] bimodal_bits;
  logic [3:0] gshare_bits;
  logic [3:0] history_bits;
  logic [3:0] chooser_bits;

  // Captured branch
  logic [INDEX_BITS-1:0] word;
  logic                  taken_q;

  // Predictor state
  logic [INDEX_BITS-1:0] history;
  logic [INDEX_BITS-1:0] clear_addr;
  logic [31:0]           branch_count;
  logic [31:0]           miss_count;

  // Counter tables and their registered read data
  logic [1:0] bim_mem [TABLE_DEPTH];
  logic [1:0] gsh_mem [TABLE_DEPTH];
  logic [1:0] cho_mem [TABLE_DEPTH];
  logic [1:0] bim_rd;
  logic [1:0] gsh_rd;
  logic [1:0] cho_rd;

  // Derived lengths and indices
  logic [3:0]            m2;
  logic [3:0]            m1;
  logic [3:0]            n;
  logic [3:0]            k;
  logic [INDEX_BITS-1:0] ghr;
  logic [INDEX_BITS-1:0] bi;
  logic [INDEX_BITS-1:0] gi;
  logic [INDEX_BITS-1:0] ci;
  logic [INDEX_BITS-1:0] history_next;

  // Update decisions
  logic       hybrid;
  logic       bp;
  logic       gp;
  logic       use_gshare;
  logic       pred;
  logic       miss;
  logic       bim_we;
  logic       gsh_we;
  logic       cho_we;
  logic [1:0] bim_wd;
  logic [1:0] gsh_wd;
  logic [1:0] cho_wd;
  logic [INDEX_BITS-1:0] bim_wa;
  logic [INDEX_BITS-1:0] gsh_wa;
  logic [INDEX_BITS-1:0] cho_wa;

  assign status.clear_last = &clear_addr;

  // Clamp index lengths and form the table indices
  always_comb begin
    m2 = clamp_bits(bimodal_bits, 4'(INDEX_BITS));
    m1 = clamp_bits(gshare_bits, 4'(INDEX_BITS));
    n  = clamp_bits(history_bits, m1);
    k  = clamp_bits(chooser_bits, 4'(INDEX_BITS));
    ghr = history & low_mask(n);
    bi = word & low_mask(m2);
    gi = (word & low_mask(m1)) ^ (ghr << (m1 - n));
    ci = word & low_mask(k);
    history_next = ((ghr >> 1) | (taken_q ? ({{(INDEX_BITS-1){1'b0}}, 1'b1} << (n - 4'd1))
                                          : '0)) & low_mask(n);
  end

  // Pick the prediction and the tables to train
  always_comb begin
    hybrid = (mode != MODE_BIMODAL) && (mode != MODE_GSHARE);
    bp = bim_rd[1];
    gp = gsh_rd[1];
    use_gshare = (mode == MODE_GSHARE) || (hybrid && cho_rd[1]);
    pred = use_gshare ? gp : bp;
    miss = (pred != taken_q);

    bim_we = cmd.clear || (cmd.commit && !use_gshare);
    gsh_we = cmd.clear || (cmd.commit && use_gshare);
    cho_we = cmd.clear || (cmd.commit && hybrid && (bp != gp));
    bim_wa = cmd.clear ? clear_addr : bi;
    gsh_wa = cmd.clear ? clear_addr : gi;
    cho_wa = cmd.clear ? clear_addr : ci;
    bim_wd = cmd.clear ? CTR_WEAK_TAKEN : train(bim_rd, taken_q);
    gsh_wd = cmd.clear ? CTR_WEAK_TAKEN : train(gsh_rd, taken_q);
    // Move the chooser toward the predictor that was right
    cho_wd = cmd.clear ? CHOOSER_RESET : train(cho_rd, taken_q != bp);
  end

  // Bimodal table
  always_ff @(posedge clk) begin
    if (bim_we) begin
      bim_mem[bim_wa] <= bim_wd;
    end
    if (cmd.read) begin
      bim_rd <= bim_mem[bi];
    end
  end

  // Gshare table
  always_ff @(posedge clk) begin
    if (gsh_we) begin
      gsh_mem[gsh_wa] <= gsh_wd;
    end
    if (cmd.read) begin
      gsh_rd <= gsh_mem[gi];
    end
  end

  // Chooser table
  always_ff @(posedge clk) begin
    if (cho_we) begin
      cho_mem[cho_wa] <= cho_wd;
    end
    if (cmd.read) begin
      cho_rd <= cho_mem[ci];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_BIMODAL;
      bimodal_bits <= 4'd6;
      gshare_bits <= 4'd9;
      history_bits <= 4'd3;
      chooser_bits <= 4'd8;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_MODE:         mode <= cfg_data[1:0];
        CFG_BIMODAL_BITS: bimodal_bits <= cfg_data;
        CFG_GSHARE_BITS:  gshare_bits <= cfg_data;
        CFG_HISTORY_BITS: history_bits <= cfg_data;
        CFG_CHOOSER_BITS: chooser_bits <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Capture the branch; only the index bits of the word address matter
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word <= branch_address[INDEX_BITS+1:2];
      taken_q <= taken;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      predicted_taken <= pred;
      mispredicted <= miss;
    end
  end

  // Sweep address, history and saturating totals
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
      history <= '0;
      branch_count <= '0;
      miss_count <= '0;
    end else begin
      if (cmd.clear) begin
        clear_addr <= clear_addr + {{(INDEX_BITS-1){1'b0}}, 1'b1};
      end
      if (cmd.commit) begin
        if (mode != MODE_BIMODAL) begin
          history <= history_next;
        end
        if (branch_count != 32'hFFFF_FFFF) begin
          branch_count <= branch_count + 32'd1;
        end
        if (miss && (miss_count != 32'hFFFF_FFFF)) begin
          miss_count <= miss_count + 32'd1;
        end
      end
    end
  end

  assign prediction_total = branch_count;
  assign mispredict_total = miss_count;

endmodule
